>>> rtl/mrse_pkg.sv
// Package for the Modbus RTU slave register engine.
// Holds request codes, function codes, command addresses and the state encoding.
package mrse_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_END   = 2'd1,
    REQ_LOCAL = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  localparam logic [7:0]  FC_READ      = 8'h03;
  localparam logic [7:0]  FC_WRITE1    = 8'h06;
  localparam logic [7:0]  FC_WRITEN    = 8'h10;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] ADDR_START   = 16'h0064;
  localparam logic [15:0] ADDR_STOP    = 16'h0065;
  localparam logic [15:0] ADDR_FRESET  = 16'h0066;
  localparam logic [15:0] ADDR_ADJUST  = 16'h0067;
  localparam logic [15:0] ADDR_MODE    = 16'h0068;
  localparam logic [15:0] VAL_START    = 16'h00AA;
  localparam logic [15:0] VAL_STOP     = 16'h00BB;
  localparam logic [15:0] VAL_FRESET   = 16'h00CC;
  localparam int unsigned READ_CAP     = 61;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,      // register file clearing sweep
    S_CRC_RD,   // issue frame buffer read for CRC
    S_CRC_BYTE, // fold byte into CRC (8 bit steps)
    S_HDR_RD,   // read the received CRC bytes, lo then hi
    S_HDR_WAIT,
    S_CHECK,
    S_WN_RD,    // function 16: read two data bytes
    S_WN_WAIT,
    S_WN_WR,
    S_TX_HDR,   // build response bytes
    S_RD_REG,
    S_RD_WAIT,
    S_TX_CRC,
    S_TX_OUT,
    S_TX_FINAL
  } state_e;

  // one CRC-16/Modbus byte update, 8 bit steps on a 16-bit value
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

>>> rtl/mrse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mrse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/modbus_rtu_slave_register_engine.sv
// Modbus RTU slave register engine: frame buffer, register file and response sequencer.
// A frame end walks the CRC over the frame bytes bit by bit; for a valid request it
// then reads or writes the addressed registers and sends the response as result
// items. Input stalls until the last result is taken. After reset the register file
// is cleared by a sweep over all REG_COUNT registers before the first item is
// accepted. Uses mrse_pkg and mrse_ram.
module modbus_rtu_slave_register_engine #(
  parameter int unsigned FRAME_BYTES = 128,
  parameter int unsigned REG_COUNT   = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_overrun_i,
  input  logic [6:0]  local_addr_i,
  input  logic [15:0] local_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  first_byte_o,
  output logic [7:0]  second_byte_o,
  output logic        second_valid_o,
  output logic        last_o,
  output logic        start_cmd_o,
  output logic        stop_cmd_o,
  output logic        fault_reset_cmd_o,
  output logic        adjust_written_o,
  output logic [15:0] adjust_value_o,
  output logic        force_mode_cmd_o,
  output logic [15:0] error_total_o
);
  localparam int unsigned FAW = $clog2(FRAME_BYTES);
  localparam int unsigned RAW = $clog2(REG_COUNT);
  localparam int unsigned LW  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned RL_RAW = (FRAME_BYTES - 5) / 2;
  localparam int unsigned READ_LIMIT = (RL_RAW > mrse_pkg::READ_CAP) ?
                                       mrse_pkg::READ_CAP : RL_RAW;
  localparam int unsigned WRITE_LIMIT = (FRAME_BYTES - 9) / 2;
  // response bytes before CRC: at most 3 + 2*61
  localparam int unsigned TXD = 128;
  localparam int unsigned TAW = 7;

  mrse_pkg::state_e state_q, state_d;

  logic [7:0]    slave_addr_q;
  logic [LW-1:0] len_q, len_d;
  logic [15:0]   err_q, err_d;

  // frame buffer
  logic           fb_we;
  logic [FAW-1:0] fb_waddr, fb_raddr;
  logic [7:0]     fb_rdata;
  // register file
  logic           rf_we;
  logic [RAW-1:0] rf_waddr, rf_raddr;
  logic [15:0]    rf_wdata, rf_rdata;
  // response buffer
  logic           tx_we;
  logic [TAW-1:0] tx_waddr, tx_raddr;
  logic [7:0]     tx_wdata, tx_rdata;

  mrse_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_fb (
    .clk_i, .we_i(fb_we), .waddr_i(fb_waddr), .wdata_i(rx_byte_i),
    .raddr_i(fb_raddr), .rdata_o(fb_rdata));
  mrse_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr), .rdata_o(rf_rdata));
  mrse_ram #(.WIDTH(8), .DEPTH(TXD)) u_tx (
    .clk_i, .we_i(tx_we), .waddr_i(tx_waddr), .wdata_i(tx_wdata),
    .raddr_i(tx_raddr), .rdata_o(tx_rdata));

  // frame-end working registers
  logic [LW-1:0]  n_q, n_d;         // frame length snapshot
  logic [LW-1:0]  idx_q, idx_d;     // general index
  logic [3:0]     bit_q, bit_d;
  logic [15:0]    crc_q, crc_d;
  logic [7:0]     h_q [9];          // bytes 0..6 and received CRC lo/hi
  logic [7:0]     h_d [9];
  logic [15:0]    start_q, start_d, cnt_q, cnt_d;
  logic [7:0]     hi_q, hi_d;       // high data byte for function 16
  logic [TAW:0]   tlen_q, tlen_d;   // response length, incl CRC once it is appended
  logic [TAW:0]   tp_q, tp_d;       // response build / output pointer
  logic           st_q, st_d, sp_q, sp_d, fr_q, fr_d, adj_q, adj_d, fm_q, fm_d;
  logic [15:0]    adjv_q, adjv_d;
  logic [RAW:0]   clr_q, clr_d;
  logic [7:0]     fb0_q, fb0_d;     // first output byte held while second is read
  // output register
  logic        ov_q, ov_d;
  logic [7:0]  ob1_q, ob1_d, ob2_q, ob2_d;
  logic        o2v_q, o2v_d, olast_q, olast_d;

  logic in_acc, cfg_acc, out_free;
  // flags and error count drive the outputs directly, so hold input while busy or while a result waits
  assign in_stall_o  = (state_q != mrse_pkg::S_IDLE) || ov_q;
  assign cfg_ready_o = 1'b1;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i;
  assign out_free = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrse_pkg::S_CLR;
      slave_addr_q <= 8'd1;
      len_q <= '0;
      err_q <= '0;
      clr_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        slave_addr_q <= cfg_data_i;
      end
      len_q <= len_d;
      err_q <= err_d;
      clr_q <= clr_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; idx_q <= idx_d; bit_q <= bit_d; crc_q <= crc_d;
    h_q <= h_d; start_q <= start_d; cnt_q <= cnt_d; hi_q <= hi_d;
    tlen_q <= tlen_d; tp_q <= tp_d; fb0_q <= fb0_d;
    st_q <= st_d; sp_q <= sp_d; fr_q <= fr_d; adj_q <= adj_d; fm_q <= fm_d;
    adjv_q <= adjv_d;
    ob1_q <= ob1_d; ob2_q <= ob2_d; o2v_q <= o2v_d; olast_q <= olast_d;
  end

  logic [15:0] rx_crc;
  logic [16:0] end_reg;
  logic        ok;
  logic [LW:0] n16;
  logic [15:0] crc_step;

  always_comb begin
    state_d = state_q;
    len_d = len_q; err_d = err_q; clr_d = clr_q;
    n_d = n_q; idx_d = idx_q; bit_d = bit_q; crc_d = crc_q; h_d = h_q;
    start_d = start_q; cnt_d = cnt_q; hi_d = hi_q; tlen_d = tlen_q; tp_d = tp_q;
    fb0_d = fb0_q;
    st_d = st_q; sp_d = sp_q; fr_d = fr_q; adj_d = adj_q; fm_d = fm_q; adjv_d = adjv_q;
    ov_d = ov_q; ob1_d = ob1_q; ob2_d = ob2_q; o2v_d = o2v_q; olast_d = olast_q;
    fb_we = 1'b0; fb_waddr = len_q[FAW-1:0]; fb_raddr = idx_q[FAW-1:0];
    rf_we = 1'b0; rf_waddr = '0; rf_wdata = '0; rf_raddr = '0;
    tx_we = 1'b0; tx_waddr = tp_q[TAW-1:0]; tx_wdata = '0; tx_raddr = tp_q[TAW-1:0];
    rx_crc = {h_q[8], h_q[7]};
    end_reg = {1'b0, start_q} + {1'b0, cnt_q};
    ok = 1'b0;
    n16 = {1'b0, n_q};
    crc_step = crc_q ^ {8'h00, fb_rdata};

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      mrse_pkg::S_CLR: begin
        rf_we = 1'b1;
        rf_waddr = clr_q[RAW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (RAW+1)'(REG_COUNT - 1)) begin
          state_d = mrse_pkg::S_IDLE;
        end
      end
      mrse_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (mrse_pkg::req_e'(req_type_i))
            mrse_pkg::REQ_BYTE: begin
              if (rx_overrun_i) begin
                err_d = err_q + 16'd1;
              end
              if (len_q < LW'(FRAME_BYTES)) begin
                fb_we = 1'b1;
                len_d = len_q + 1'b1;
              end else begin
                len_d = '0;
              end
            end
            mrse_pkg::REQ_END: begin
              n_d = len_q;
              len_d = '0;
              st_d = 1'b0; sp_d = 1'b0; fr_d = 1'b0; adj_d = 1'b0; fm_d = 1'b0;
              adjv_d = '0;
              crc_d = mrse_pkg::CRC_INIT;
              idx_d = '0;
              if (len_q >= LW'(4)) begin
                state_d = mrse_pkg::S_CRC_RD;
              end
            end
            mrse_pkg::REQ_LOCAL: begin
              if ({9'd0, local_addr_i} < 16'(REG_COUNT)) begin
                rf_we = 1'b1;
                rf_waddr = RAW'(local_addr_i);
                rf_wdata = local_value_i;
              end
            end
            default: ;
          endcase
        end
      end
      mrse_pkg::S_CRC_RD: begin
        // read byte idx; header bytes are captured on the way
        fb_raddr = idx_q[FAW-1:0];
        bit_d = '0;
        state_d = mrse_pkg::S_CRC_BYTE;
      end
      mrse_pkg::S_CRC_BYTE: begin
        if (bit_q == 4'd0) begin
          if (idx_q < LW'(7)) begin
            h_d[idx_q[3:0]] = fb_rdata;
          end
          crc_d = crc_step[0] ? ((crc_step >> 1) ^ mrse_pkg::CRC_POLY) : (crc_step >> 1);
          bit_d = 4'd1;
        end else begin
          crc_d = crc_q[0] ? ((crc_q >> 1) ^ mrse_pkg::CRC_POLY) : (crc_q >> 1);
          bit_d = bit_q + 4'd1;
          if (bit_q == 4'd7) begin
            idx_d = idx_q + 1'b1;
            if (idx_q + 1'b1 == n_q - LW'(2)) begin
              state_d = mrse_pkg::S_HDR_RD;
              idx_d = n_q - LW'(2);
            end else begin
              state_d = mrse_pkg::S_CRC_RD;
            end
          end
        end
      end
      mrse_pkg::S_HDR_RD: begin
        // fetch received CRC lo, then hi
        fb_raddr = idx_q[FAW-1:0];
        state_d = mrse_pkg::S_HDR_WAIT;
      end
      mrse_pkg::S_HDR_WAIT: begin
        if (idx_q == n_q - LW'(2)) begin
          h_d[7] = fb_rdata;
          idx_d = idx_q + 1'b1;
          state_d = mrse_pkg::S_HDR_RD;
        end else begin
          h_d[8] = fb_rdata;
          state_d = mrse_pkg::S_CHECK;
        end
      end
      mrse_pkg::S_CHECK: begin
        start_d = {h_q[2], h_q[3]};
        cnt_d = {h_q[4], h_q[5]};
        end_reg = {1'b0, h_q[2], h_q[3]} + {1'b0, h_q[4], h_q[5]};
        state_d = mrse_pkg::S_IDLE;
        if (h_q[0] == slave_addr_q && crc_q == rx_crc) begin
          unique case (h_q[1])
            mrse_pkg::FC_READ: begin
              ok = (n_q == LW'(8)) && ({h_q[4], h_q[5]} != 16'd0) &&
                   ({h_q[4], h_q[5]} <= 16'(READ_LIMIT)) &&
                   ({h_q[2], h_q[3]} < 16'(REG_COUNT)) &&
                   (end_reg <= 17'(REG_COUNT));
              if (ok) begin
                tp_d = '0;
                tlen_d = (TAW+1)'(3) + {h_q[5][TAW-1:0], 1'b0};
                crc_d = mrse_pkg::CRC_INIT;
                state_d = mrse_pkg::S_TX_HDR;
              end
            end
            mrse_pkg::FC_WRITE1: begin
              ok = (n_q == LW'(8)) && ({h_q[2], h_q[3]} < 16'(REG_COUNT));
              if (ok) begin
                rf_we = 1'b1;
                rf_waddr = RAW'({h_q[2], h_q[3]});
                rf_wdata = {h_q[4], h_q[5]};
                st_d = ({h_q[2], h_q[3]} == mrse_pkg::ADDR_START) &&
                       ({h_q[4], h_q[5]} == mrse_pkg::VAL_START);
                sp_d = ({h_q[2], h_q[3]} == mrse_pkg::ADDR_STOP) &&
                       ({h_q[4], h_q[5]} == mrse_pkg::VAL_STOP);
                fr_d = ({h_q[2], h_q[3]} == mrse_pkg::ADDR_FRESET) &&
                       ({h_q[4], h_q[5]} == mrse_pkg::VAL_FRESET);
                adj_d = ({h_q[2], h_q[3]} == mrse_pkg::ADDR_ADJUST);
                adjv_d = adj_d ? {h_q[4], h_q[5]} : 16'd0;
                fm_d = ({h_q[2], h_q[3]} == mrse_pkg::ADDR_MODE);
                tp_d = '0;
                tlen_d = (TAW+1)'(6);
                crc_d = mrse_pkg::CRC_INIT;
                state_d = mrse_pkg::S_TX_HDR;
              end
            end
            mrse_pkg::FC_WRITEN: begin
              ok = (n_q >= LW'(9)) && ({h_q[4], h_q[5]} != 16'd0) &&
                   ({h_q[4], h_q[5]} <= 16'(WRITE_LIMIT)) &&
                   ({8'd0, h_q[6]} == {h_q[4], h_q[5]} << 1) &&
                   ({1'b0, n16} == (LW+2)'(h_q[6]) + (LW+2)'(9)) &&
                   ({h_q[2], h_q[3]} < 16'(REG_COUNT)) &&
                   (end_reg <= 17'(REG_COUNT));
              if (ok) begin
                idx_d = LW'(7);
                state_d = mrse_pkg::S_WN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      mrse_pkg::S_WN_RD: begin
        fb_raddr = idx_q[FAW-1:0];
        idx_d = idx_q + 1'b1;
        state_d = mrse_pkg::S_WN_WAIT;
      end
      mrse_pkg::S_WN_WAIT: begin
        hi_d = fb_rdata;
        fb_raddr = idx_q[FAW-1:0];
        idx_d = idx_q + 1'b1;
        state_d = mrse_pkg::S_WN_WR;
      end
      mrse_pkg::S_WN_WR: begin
        rf_we = 1'b1;
        rf_waddr = RAW'(start_q);
        rf_wdata = {hi_q, fb_rdata};
        start_d = start_q + 16'd1;
        cnt_d = cnt_q - 16'd1;
        if (cnt_q == 16'd1) begin
          tp_d = '0;
          tlen_d = (TAW+1)'(6);
          crc_d = mrse_pkg::CRC_INIT;
          state_d = mrse_pkg::S_TX_HDR;
        end else begin
          state_d = mrse_pkg::S_WN_RD;
        end
      end
      mrse_pkg::S_TX_HDR: begin
        // header bytes; for reads the third byte is the byte count
        tx_we = 1'b1;
        tx_waddr = tp_q[TAW-1:0];
        if (tp_q == '0) begin
          tx_wdata = slave_addr_q;
        end else if (tp_q == (TAW+1)'(2) && h_q[1] == mrse_pkg::FC_READ) begin
          tx_wdata = {cnt_q[6:0], 1'b0};
        end else begin
          tx_wdata = h_q[tp_q[3:0]];
        end
        crc_d = mrse_pkg::crc_byte(crc_q, tx_wdata);
        tp_d = tp_q + 1'b1;
        if (h_q[1] == mrse_pkg::FC_READ && tp_q == (TAW+1)'(2)) begin
          state_d = mrse_pkg::S_RD_REG;
        end else if (tp_q == (TAW+1)'(5)) begin
          state_d = mrse_pkg::S_TX_CRC;
        end
      end
      mrse_pkg::S_RD_REG: begin
        rf_raddr = RAW'(start_q);
        state_d = mrse_pkg::S_RD_WAIT;
        bit_d = '0;
      end
      mrse_pkg::S_RD_WAIT: begin
        // high byte, then low byte
        rf_raddr = RAW'(start_q);
        tx_we = 1'b1;
        tx_waddr = tp_q[TAW-1:0];
        tx_wdata = (bit_q == 4'd0) ? rf_rdata[15:8] : rf_rdata[7:0];
        crc_d = mrse_pkg::crc_byte(crc_q, tx_wdata);
        tp_d = tp_q + 1'b1;
        bit_d = 4'd1;
        if (bit_q != 4'd0) begin
          start_d = start_q + 16'd1;
          cnt_d = cnt_q - 16'd1;
          state_d = (cnt_q == 16'd1) ? mrse_pkg::S_TX_CRC : mrse_pkg::S_RD_REG;
        end
      end
      mrse_pkg::S_TX_CRC: begin
        // append CRC lo, hi; the length is known to fit
        tx_we = 1'b1;
        tx_waddr = tp_q[TAW-1:0];
        tx_wdata = (tp_q == tlen_q) ? crc_q[7:0] : crc_q[15:8];
        tp_d = tp_q + 1'b1;
        if (tp_q != tlen_q) begin
          tlen_d = tlen_q + (TAW+1)'(2);
          tp_d = '0;
          bit_d = '0;
          state_d = mrse_pkg::S_TX_OUT;
        end
      end
      mrse_pkg::S_TX_OUT: begin
        // read byte pair: tp then tp+1
        tx_raddr = tp_q[TAW-1:0];
        if (bit_q == 4'd0) begin
          bit_d = 4'd1;
          tp_d = tp_q + 1'b1;
        end else begin
          state_d = mrse_pkg::S_TX_FINAL;
          fb0_d = tx_rdata;
        end
      end
      mrse_pkg::S_TX_FINAL: begin
        if (out_free) begin
          ov_d = 1'b1;
          ob1_d = fb0_q;
          o2v_d = (tp_q < tlen_q);
          ob2_d = (tp_q < tlen_q) ? tx_rdata : 8'd0;
          olast_d = (tp_q + 1'b1 >= tlen_q);
          tp_d = tp_q + 1'b1;
          bit_d = '0;
          state_d = (tp_q + 1'b1 >= tlen_q) ? mrse_pkg::S_IDLE : mrse_pkg::S_TX_OUT;
        end
        tx_raddr = tp_q[TAW-1:0];
      end
      default: state_d = mrse_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o       = ov_q;
  assign first_byte_o      = ob1_q;
  assign second_byte_o     = ob2_q;
  assign second_valid_o    = o2v_q;
  assign last_o            = olast_q;
  assign start_cmd_o       = st_q;
  assign stop_cmd_o        = sp_q;
  assign fault_reset_cmd_o = fr_q;
  assign adjust_written_o  = adj_q;
  assign adjust_value_o    = adjv_q;
  assign force_mode_cmd_o  = fm_q;
  assign error_total_o     = err_q;

endmodule
